FILE: rtl/core/eda_pkg.sv
package eda_pkg;

  // Default longest string held for each side.
  localparam int unsigned MaxLen = 32;

  // Field widths of the words on the two channels.
  localparam int unsigned OpWidth   = 2;
  localparam int unsigned SymWidth  = 8;
  localparam int unsigned CodeWidth = 3;

  // Operation codes of an input word.
  localparam logic [OpWidth-1:0] OP_ENTERED   = 2'd0;
  localparam logic [OpWidth-1:0] OP_REFERENCE = 2'd1;
  localparam logic [OpWidth-1:0] OP_RUN       = 2'd2;

  // Direction kept for each cost cell; the same values serve as edit codes.
  localparam logic [1:0] DIR_MATCH = 2'd0;
  localparam logic [1:0] DIR_SUBST = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  // Edit code sent when both strings are empty.
  localparam logic [CodeWidth-1:0] CODE_EMPTY = 3'd4;

endpackage

FILE: rtl/core/eda_stream_if.sv
// Input channel: one operation with its byte per word.
interface eda_in_if;
  logic                              valid;
  logic                              ready;
  logic [eda_pkg::OpWidth-1:0]       operation;
  logic [eda_pkg::SymWidth-1:0]      symbol;

  modport source (output valid, output operation, output symbol, input ready);
  modport sink   (input valid, input operation, input symbol, output ready);
endinterface

// Output channel: one edit code per word, the final one marked.
interface eda_out_if;
  logic                              valid;
  logic                              ready;
  logic [eda_pkg::CodeWidth-1:0]     edit_code;
  logic                              last;

  modport source (output valid, output edit_code, output last, input ready);
  modport sink   (input valid, input edit_code, input last, output ready);
endinterface

FILE: rtl/core/eda_cell_unit.sv
// Shared cost unit: evaluates one cell of the cost table from its three
// neighbours and picks the direction taken into the cell.
module eda_cell_unit #(
  parameter int unsigned CW = 6
) (
  input  logic [CW-1:0] diag_i,
  input  logic [CW-1:0] left_i,
  input  logic [CW-1:0] up_i,
  input  logic          differ_i,
  output logic [CW-1:0] cost_o,
  output logic [1:0]    dir_o
);

  logic          left_lt_up;
  logic [CW-1:0] side_cost;
  logic [CW-1:0] diag_cost;

  // One plus the smaller of the left and upper costs.
  assign left_lt_up = (left_i < up_i);
  assign side_cost  = (left_lt_up ? left_i : up_i) + CW'(1);
  assign diag_cost  = diag_i + CW'(differ_i);

  // The diagonal wins only when strictly cheaper.
  always_comb begin
    if (diag_cost < side_cost) begin
      cost_o = diag_cost;
      dir_o  = differ_i ? eda_pkg::DIR_SUBST : eda_pkg::DIR_MATCH;
    end else begin
      cost_o = side_cost;
      dir_o  = left_lt_up ? eda_pkg::DIR_LEFT : eda_pkg::DIR_UP;
    end
  end

endmodule

FILE: rtl/core/edit_distance_alignment.sv
// Channel | Dir | Word contents
// in_i    | in  | operation (append entered, append reference, run), symbol byte
// out_o   | out | edit_code (match, substitute, delete, insert, empty), last
//
// Load words are taken one per cycle while the block is idle. A run on two
// non-empty strings of lengths en and cn keeps the input closed through the fill
// and a traceback of at most en + cn steps, as every cost cell needs a read and
// a write of the single-port cost row, every step a read of the direction memory
// and the output load. A stalled output holds the traceback in place. Reset
// clears the lengths, the sequencer and the output register, not the memories.
module edit_distance_alignment #(
  parameter int unsigned MAX_LEN = eda_pkg::MaxLen
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  eda_in_if.sink     in_i,
  eda_out_if.source  out_o
);

  localparam int unsigned IW     = $clog2(MAX_LEN + 1);
  localparam int unsigned SAW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CW     = $clog2(MAX_LEN + 2);
  localparam int unsigned Depth  = (MAX_LEN + 1) * (MAX_LEN + 1);
  localparam int unsigned DW     = $clog2(Depth);
  localparam logic [DW-1:0] RowStride = DW'(MAX_LEN + 1);
  localparam logic [IW-1:0] MaxCount  = IW'(MAX_LEN);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EMPTY,
    S_INIT,
    S_ROW,
    S_CELL_RD,
    S_CELL_WR,
    S_TB_RD,
    S_TB_EMIT
  } state_e;

  state_e state_q;

  logic [IW-1:0] ent_cnt_q, ref_cnt_q;
  logic [IW-1:0] en_q, cn_q;
  logic [IW-1:0] ei_q, ci_q;
  logic [DW-1:0] row_base_q;
  logic [CW-1:0] diag_q, left_q;

  logic                          out_vld_q;
  logic [eda_pkg::CodeWidth-1:0] out_code_q;
  logic                          out_last_q;

  // Memories and their registered read data.
  logic [eda_pkg::SymWidth-1:0] ent_mem [MAX_LEN];
  logic [eda_pkg::SymWidth-1:0] ref_mem [MAX_LEN];
  logic [CW-1:0]                row_mem [MAX_LEN + 1];
  logic [1:0]                   dir_mem [Depth];

  logic [eda_pkg::SymWidth-1:0] ent_rd_q, ref_rd_q;
  logic [CW-1:0]                row_rd_q;
  logic [1:0]                   dir_rd_q;

  logic          in_fire;
  logic          out_free;
  logic          out_load;
  logic          ent_wr, ref_wr, ent_rd, ref_rd;
  logic          row_wr, row_rd, dir_wr, dir_rd;
  logic [CW-1:0] row_wdata;
  logic [DW-1:0] dir_addr;
  logic [CW-1:0] cell_cost;
  logic [1:0]    cell_dir;

  logic [1:0]    tb_dir;
  logic [IW-1:0] tb_ei_d, tb_ci_d;
  logic [DW-1:0] tb_base_d;
  logic          tb_last;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_vld_q || out_o.ready;
  assign out_load   = out_free && ((state_q == S_EMPTY) || (state_q == S_TB_EMIT));

  assign out_o.valid     = out_vld_q;
  assign out_o.edit_code = out_code_q;
  assign out_o.last      = out_last_q;

  // Memory controls follow the sequencer state.
  always_comb begin
    ent_wr    = in_fire && (in_i.operation == eda_pkg::OP_ENTERED) && (ent_cnt_q < MaxCount);
    ref_wr    = in_fire && (in_i.operation == eda_pkg::OP_REFERENCE) && (ref_cnt_q < MaxCount);
    ent_rd    = (state_q == S_ROW);
    ref_rd    = (state_q == S_CELL_RD);
    row_rd    = (state_q == S_CELL_RD);
    row_wr    = (state_q == S_INIT) || (state_q == S_CELL_WR);
    row_wdata = (state_q == S_INIT) ? CW'(ci_q) : cell_cost;
    dir_wr    = (state_q == S_CELL_WR);
    dir_rd    = (state_q == S_TB_RD);
    dir_addr  = row_base_q + DW'(ci_q);
  end

  // String memories, written on load and read during the fill.
  always_ff @(posedge clk_i) begin
    if (ent_wr) begin
      ent_mem[ent_cnt_q[SAW-1:0]] <= in_i.symbol;
    end
    if (ref_wr) begin
      ref_mem[ref_cnt_q[SAW-1:0]] <= in_i.symbol;
    end
    if (ent_rd) begin
      ent_rd_q <= ent_mem[SAW'(ei_q - IW'(1))];
    end
    if (ref_rd) begin
      ref_rd_q <= ref_mem[SAW'(ci_q - IW'(1))];
    end
  end

  // Cost row, updated in place one cell at a time.
  always_ff @(posedge clk_i) begin
    if (row_wr) begin
      row_mem[ci_q] <= row_wdata;
    end
    if (row_rd) begin
      row_rd_q <= row_mem[ci_q];
    end
  end

  // Direction store for the whole table.
  always_ff @(posedge clk_i) begin
    if (dir_wr) begin
      dir_mem[dir_addr] <= cell_dir;
    end
    if (dir_rd) begin
      dir_rd_q <= dir_mem[dir_addr];
    end
  end

  eda_cell_unit #(
    .CW (CW)
  ) u_cell (
    .diag_i   (diag_q),
    .left_i   (left_q),
    .up_i     (row_rd_q),
    .differ_i (ent_rd_q != ref_rd_q),
    .cost_o   (cell_cost),
    .dir_o    (cell_dir)
  );

  // Traceback step: the table edges force the direction.
  always_comb begin
    tb_ei_d   = ei_q;
    tb_ci_d   = ci_q;
    tb_base_d = row_base_q;
    if (ei_q == '0) begin
      tb_dir = eda_pkg::DIR_LEFT;
    end else if (ci_q == '0) begin
      tb_dir = eda_pkg::DIR_UP;
    end else begin
      tb_dir = dir_rd_q;
    end
    unique case (tb_dir)
      eda_pkg::DIR_MATCH, eda_pkg::DIR_SUBST: begin
        tb_ei_d   = ei_q - IW'(1);
        tb_ci_d   = ci_q - IW'(1);
        tb_base_d = row_base_q - RowStride;
      end
      eda_pkg::DIR_UP: begin
        tb_ei_d   = ei_q - IW'(1);
        tb_base_d = row_base_q - RowStride;
      end
      default: begin
        tb_ci_d = ci_q - IW'(1);
      end
    endcase
    tb_last = (tb_ei_d == '0) && (tb_ci_d == '0);
  end

  // Sequencer with counts and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      ent_cnt_q  <= '0;
      ref_cnt_q  <= '0;
      en_q       <= '0;
      cn_q       <= '0;
      ei_q       <= '0;
      ci_q       <= '0;
      row_base_q <= '0;
      diag_q     <= '0;
      left_q     <= '0;
      out_vld_q  <= 1'b0;
      out_code_q <= '0;
      out_last_q <= 1'b0;
    end else begin
      // The output word is loaded, or dropped once it has been taken.
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (ent_wr) begin
            ent_cnt_q <= ent_cnt_q + IW'(1);
          end
          if (ref_wr) begin
            ref_cnt_q <= ref_cnt_q + IW'(1);
          end
          if (in_fire && (in_i.operation == eda_pkg::OP_RUN)) begin
            en_q       <= ent_cnt_q;
            cn_q       <= ref_cnt_q;
            ei_q       <= ent_cnt_q;
            ci_q       <= ref_cnt_q;
            ent_cnt_q  <= '0;
            ref_cnt_q  <= '0;
            row_base_q <= '0;
            if ((ent_cnt_q == '0) && (ref_cnt_q == '0)) begin
              state_q <= S_EMPTY;
            end else if ((ent_cnt_q == '0) || (ref_cnt_q == '0)) begin
              state_q <= S_TB_RD;
            end else begin
              ci_q    <= IW'(1);
              state_q <= S_INIT;
            end
          end
        end
        S_EMPTY: begin
          if (out_free) begin
            out_code_q <= eda_pkg::CODE_EMPTY;
            out_last_q <= 1'b1;
            state_q    <= S_IDLE;
          end
        end
        // First row of costs: cell ci costs ci.
        S_INIT: begin
          if (ci_q == cn_q) begin
            ei_q    <= IW'(1);
            state_q <= S_ROW;
          end else begin
            ci_q <= ci_q + IW'(1);
          end
        end
        // Row set-up: the left edge costs ei, its upper neighbour ei - 1.
        S_ROW: begin
          row_base_q <= row_base_q + RowStride;
          ci_q       <= IW'(1);
          diag_q     <= CW'(ei_q - IW'(1));
          left_q     <= CW'(ei_q);
          state_q    <= S_CELL_RD;
        end
        S_CELL_RD: begin
          state_q <= S_CELL_WR;
        end
        S_CELL_WR: begin
          diag_q <= row_rd_q;
          left_q <= cell_cost;
          if (ci_q != cn_q) begin
            ci_q    <= ci_q + IW'(1);
            state_q <= S_CELL_RD;
          end else if (ei_q != en_q) begin
            ei_q    <= ei_q + IW'(1);
            state_q <= S_ROW;
          end else begin
            state_q <= S_TB_RD;
          end
        end
        S_TB_RD: begin
          state_q <= S_TB_EMIT;
        end
        S_TB_EMIT: begin
          if (out_free) begin
            out_code_q <= {1'b0, tb_dir};
            out_last_q <= tb_last;
            ei_q       <= tb_ei_d;
            ci_q       <= tb_ci_d;
            row_base_q <= tb_base_d;
            state_q    <= tb_last ? S_IDLE : S_TB_RD;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // The lengths never pass the string capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ent_cnt_q <= MaxCount) && (ref_cnt_q <= MaxCount))
    else $error("string length beyond capacity");

  // A run clears both lengths.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_i.operation == eda_pkg::OP_RUN) |=> (ent_cnt_q == '0) && (ref_cnt_q == '0))
    else $error("lengths not cleared by run");

  // Cells are only evaluated inside the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CELL_WR) |-> (ci_q != '0) && (ci_q <= cn_q) && (ei_q != '0) && (ei_q <= en_q))
    else $error("cell index outside table");

  // No cost exceeds the string capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CELL_WR) |-> (cell_cost <= CW'(MAX_LEN)))
    else $error("cell cost out of range");

  // The marked final code ends the traceback and frees the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TB_EMIT) && out_free && tb_last |=> (state_q == S_IDLE) && out_last_q)
    else $error("traceback did not end on final code");

endmodule
